@@ design/assert_macros.svh @@
// Assertion macros used by the checker module of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/mbps_pkg.sv @@
// Package with shared types and constants of the masked byte pattern scanner.
package mbps_pkg;

    // Number of pattern bytes held in the configuration registers.
    localparam int PATTERN_BYTES = 16;
    localparam int ADDR_W        = 48;
    localparam int OFFSET_W      = 24;
    localparam int LEN_W         = 5;
    localparam int SKIP_W        = 16;
    localparam int APB_DATA_W    = 64;
    localparam int APB_ADDR_W    = 6;
    localparam int REG_IDX_W     = 3;

    // Register indexes, at byte address 8 * index.
    typedef enum logic [REG_IDX_W-1:0] {
        REG_PATTERN_LOW  = 3'd0,
        REG_PATTERN_HIGH = 3'd1,
        REG_CARE_MASK    = 3'd2,
        REG_PATTERN_LEN  = 3'd3,
        REG_SKIP_COUNT   = 3'd4,
        REG_BASE_ADDRESS = 3'd5
    } t_reg_idx;

    // Configuration as seen by the datapath.
    typedef struct packed {
        logic [63:0]              pattern_low;
        logic [63:0]              pattern_high;
        logic [PATTERN_BYTES-1:0] care_mask;
        logic [LEN_W-1:0]         pattern_len;
        logic [SKIP_W-1:0]        skip_count;
        logic [ADDR_W-1:0]        base_address;
    } t_cfg;

endpackage

@@ design/masked_byte_pattern_scan_top.sv @@
// Top level of the masked byte pattern scanner: window, counters and result register.
// A result is registered, so it appears on the output in the cycle after its byte.
// Throughput: one byte per cycle; compare and counter update are combinational.
// A result waiting in the output register holds bytes off unless the sink takes it.
// Reset (synchronous, active low) clears the scan state, the result valid and the
// registers to their defaults (pattern length one, everything else zero).
module masked_byte_pattern_scan_top
    import mbps_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES = 16,
    parameter int OFFSET_BITS       = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Byte stream.
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_last,
    // Result.
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_found,
    output logic [OFFSET_W-1:0]   o_match_offset,
    output logic [ADDR_W-1:0]     o_match_address,
    // Configuration.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int WIN_W  = MAX_PATTERN_BYTES * 8;
    localparam int NLEN_W = $clog2(MAX_PATTERN_BYTES + 1);
    localparam int CLAMP_W = 8;

    t_cfg cfg;

    // Scan state.
    logic [WIN_W-1:0]       r_window;
    logic [OFFSET_BITS-1:0] r_seen;
    logic [SKIP_W-1:0]      r_matches;
    logic                   r_reported;
    logic [WIN_W-1:0]       n_window;
    logic [OFFSET_BITS-1:0] n_seen;
    logic [SKIP_W-1:0]      n_matches;
    logic                   n_reported;

    // Result register.
    logic                  r_out_valid;
    logic                  r_found;
    logic [OFFSET_W-1:0]   r_offset;
    logic [ADDR_W-1:0]     r_address;
    logic                  n_out_valid;
    logic                  n_found;
    logic [OFFSET_W-1:0]   n_offset;
    logic [ADDR_W-1:0]     n_address;

    logic                   accept;
    logic                   active;
    logic                   full;
    logic                   hit;
    logic                   report;
    logic [CLAMP_W-1:0]     len_ext;
    logic [NLEN_W-1:0]      len_used;
    logic [OFFSET_BITS-1:0] offset;
    logic [OFFSET_W-1:0]    offset_out;

    mbps_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Effective pattern length: zero acts as one, clamped to the window depth.
    always_comb begin
        len_ext = CLAMP_W'(cfg.pattern_len);
        if (len_ext == '0) begin
            len_used = NLEN_W'(1);
        end else if (len_ext > CLAMP_W'(MAX_PATTERN_BYTES)) begin
            len_used = NLEN_W'(MAX_PATTERN_BYTES);
        end else begin
            len_used = NLEN_W'(len_ext);
        end
    end

    // Window after shifting in the current byte, newest byte on top.
    assign n_window = {i_data_byte, r_window[WIN_W-1:8]};

    mbps_match #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
    ) u_match (
        .i_window       (n_window),
        .i_len          (len_used),
        .i_pattern_low  (cfg.pattern_low),
        .i_pattern_high (cfg.pattern_high),
        .i_care_mask    (cfg.care_mask),
        .o_hit          (hit)
    );

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    // Scanning stops once reported or once the byte count saturates.
    assign active = !r_reported && (r_seen != {OFFSET_BITS{1'b1}});
    // The window lies wholly in the region once len bytes have arrived.
    assign full   = r_seen >= OFFSET_BITS'(len_used - NLEN_W'(1));
    assign report = active && full && hit && (r_matches == cfg.skip_count);
    assign offset = r_seen - OFFSET_BITS'(len_used - NLEN_W'(1));
    assign offset_out = OFFSET_W'(offset);

    // Next scan state and result for an accepted item.
    always_comb begin
        n_seen      = r_seen;
        n_matches   = r_matches;
        n_reported  = r_reported;
        n_out_valid = r_out_valid && !i_out_ready;
        n_found     = r_found;
        n_offset    = r_offset;
        n_address   = r_address;
        if (accept) begin
            if (active) begin
                n_seen = r_seen + OFFSET_BITS'(1);
                if (full && hit) begin
                    if (report) begin
                        n_reported = 1'b1;
                    end else begin
                        n_matches = r_matches + SKIP_W'(1);
                    end
                end
            end
            if (report) begin
                n_out_valid = 1'b1;
                n_found     = 1'b1;
                n_offset    = offset_out;
                n_address   = cfg.base_address + ADDR_W'(offset_out);
            end else if (i_last && !r_reported) begin
                n_out_valid = 1'b1;
                n_found     = 1'b0;
                n_offset    = '0;
                n_address   = '0;
            end
            // The final byte re-arms the scan for the next region.
            if (i_last) begin
                n_seen     = '0;
                n_matches  = '0;
                n_reported = 1'b0;
            end
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen      <= '0;
            r_matches   <= '0;
            r_reported  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_seen      <= n_seen;
            r_matches   <= n_matches;
            r_reported  <= n_reported;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload: window bytes and result fields.
    always_ff @(posedge i_clk) begin
        if (accept && active) begin
            r_window <= n_window;
        end
        r_found   <= n_found;
        r_offset  <= n_offset;
        r_address <= n_address;
    end

    assign o_out_valid     = r_out_valid;
    assign o_found         = r_found;
    assign o_match_offset  = r_offset;
    assign o_match_address = r_address;

endmodule

@@ design/mbps_regs.sv @@
// APB configuration register file of the masked byte pattern scanner.
module mbps_regs
    import mbps_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg       r_cfg;
    t_cfg       n_cfg;
    logic       wr_en;
    t_reg_idx   reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = t_reg_idx'(paddr[APB_ADDR_W-1:3]);
    assign o_cfg   = r_cfg;

    // Write decode; indexes past the register list are ignored.
    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_PATTERN_LOW:  n_cfg.pattern_low  = pwdata;
                REG_PATTERN_HIGH: n_cfg.pattern_high = pwdata;
                REG_CARE_MASK:    n_cfg.care_mask    = pwdata[PATTERN_BYTES-1:0];
                REG_PATTERN_LEN:  n_cfg.pattern_len  = pwdata[LEN_W-1:0];
                REG_SKIP_COUNT:   n_cfg.skip_count   = pwdata[SKIP_W-1:0];
                REG_BASE_ADDRESS: n_cfg.base_address = pwdata[ADDR_W-1:0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pattern_low  <= '0;
            r_cfg.pattern_high <= '0;
            r_cfg.care_mask    <= '0;
            r_cfg.pattern_len  <= LEN_W'(1);
            r_cfg.skip_count   <= '0;
            r_cfg.base_address <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Read decode.
    always_comb begin
        unique case (reg_idx)
            REG_PATTERN_LOW:  prdata = r_cfg.pattern_low;
            REG_PATTERN_HIGH: prdata = r_cfg.pattern_high;
            REG_CARE_MASK:    prdata = APB_DATA_W'(r_cfg.care_mask);
            REG_PATTERN_LEN:  prdata = APB_DATA_W'(r_cfg.pattern_len);
            REG_SKIP_COUNT:   prdata = APB_DATA_W'(r_cfg.skip_count);
            REG_BASE_ADDRESS: prdata = APB_DATA_W'(r_cfg.base_address);
            default:          prdata = '0;
        endcase
    end

endmodule

@@ design/mbps_match.sv @@
// Masked comparison of the newest window bytes with the configured pattern.
module mbps_match
    import mbps_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES = 16
) (
    input  logic [MAX_PATTERN_BYTES*8-1:0]        i_window,
    input  logic [$clog2(MAX_PATTERN_BYTES+1)-1:0] i_len,
    input  logic [63:0]                           i_pattern_low,
    input  logic [63:0]                           i_pattern_high,
    input  logic [PATTERN_BYTES-1:0]              i_care_mask,
    output logic                                  o_hit
);

    localparam int NLEN_W    = $clog2(MAX_PATTERN_BYTES + 1);
    localparam int IDX_W     = $clog2(MAX_PATTERN_BYTES);
    localparam int CMP_BYTES = (MAX_PATTERN_BYTES < PATTERN_BYTES) ?
                               MAX_PATTERN_BYTES : PATTERN_BYTES;

    logic [PATTERN_BYTES*8-1:0] pattern;
    logic [IDX_W-1:0]           idx;

    assign pattern = {i_pattern_high, i_pattern_low};

    // Pattern byte k lines up with window byte MAX - len + k; the newest byte is on top.
    // Pattern bytes beyond the register set are always don't-care.
    always_comb begin
        o_hit = 1'b1;
        idx   = '0;
        for (int k = 0; k < CMP_BYTES; k++) begin
            idx = IDX_W'(MAX_PATTERN_BYTES - int'(i_len) + k);
            if ((NLEN_W'(k) < i_len) && i_care_mask[k]) begin
                if (i_window[8*idx +: 8] != pattern[8*k +: 8]) begin
                    o_hit = 1'b0;
                end
            end
        end
    end

endmodule

@@ design/mbps_checker.sv @@
// Port-level checker of the masked byte pattern scanner, bound to the top level.
`include "assert_macros.svh"

module mbps_checker
    import mbps_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input logic                o_found,
    input logic [OFFSET_W-1:0] o_match_offset,
    input logic [ADDR_W-1:0]   o_match_address
);

    // A stalled result holds its fields.
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_found) && $stable(o_match_offset) && $stable(o_match_address), "stalled result changed")

    // A not-found result carries zero offset and address.
    `ASSERT_IMPLIES(a_miss_zero, i_clk, i_rst_n, o_out_valid && !o_found, o_match_offset == '0 && o_match_address == '0, "not-found result has nonzero fields")

    // An empty result register never blocks the input.
    `ASSERT_IMPLIES(a_ready_empty, i_clk, i_rst_n, !o_out_valid, o_in_ready, "input stalled with empty output")

    // A result being taken frees the input in the same cycle.
    `ASSERT_IMPLIES(a_ready_drain, i_clk, i_rst_n, o_out_valid && i_out_ready, o_in_ready, "input stalled while result drains")

endmodule

bind masked_byte_pattern_scan_top mbps_checker u_mbps_checker (.*);

@@ bench/masked_byte_pattern_scan_checker.sv @@
`timescale 1ns / 1ps
// Checker for the masked byte pattern scanner: predicts each scan result and compares it.
module masked_byte_pattern_scan_checker
    import mbps_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_last,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic                  i_found,
    input  logic [OFFSET_W-1:0]   i_match_offset,
    input  logic [ADDR_W-1:0]     i_match_address,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic                  i_pready,
    input  logic [APB_ADDR_W-1:0] i_paddr,
    input  logic [APB_DATA_W-1:0] i_pwdata,
    output int unsigned           o_fail_count,
    output int unsigned           o_pending
);

    typedef struct packed {
        logic                found;
        logic [OFFSET_W-1:0] offset;
        logic [ADDR_W-1:0]   address;
    } t_scan_result;

    localparam logic [OFFSET_W-1:0] REGION_BYTES_MAX = '1;

    // Shadow copy of the configuration registers.
    logic [8*PATTERN_BYTES-1:0] sig_bytes;
    logic [PATTERN_BYTES-1:0]   sig_care;
    logic [LEN_W-1:0]           sig_len;
    logic [SKIP_W-1:0]          skip_target;
    logic [ADDR_W-1:0]          region_base;

    // Scan state of the region in progress; the newest byte sits at the top index.
    logic [7:0]          recent_bytes [PATTERN_BYTES];
    logic [OFFSET_W-1:0] region_bytes;
    logic [SKIP_W-1:0]   passed_matches;
    logic                hit_reported;

    t_scan_result scan_results_due[$];
    int unsigned  fail_count = 0;

    // Pattern length in use: zero acts as one, anything above the window acts as the window.
    function automatic int unsigned active_len();
        if (sig_len == 0) return 1;
        if (sig_len > PATTERN_BYTES) return PATTERN_BYTES;
        return int'(sig_len);
    endfunction

    // Compares the newest n window bytes with the pattern, skipping don't-care bytes.
    function automatic logic window_hit(int unsigned n);
        for (int unsigned k = 0; k < n; k++) begin
            if (sig_care[k] && sig_bytes[8*k +: 8] != recent_bytes[PATTERN_BYTES - n + k])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic clear_region();
        foreach (recent_bytes[i]) recent_bytes[i] = '0;
        region_bytes   = '0;
        passed_matches = '0;
        hit_reported   = 1'b0;
    endtask

    // Advances the scan by one item and queues the result it causes, if any.
    task automatic scan_byte(input logic [7:0] b, input logic fin);
        int unsigned         n;
        logic [OFFSET_W-1:0] off;
        n = active_len();
        if (!hit_reported && region_bytes != REGION_BYTES_MAX) begin
            for (int i = 0; i < PATTERN_BYTES - 1; i++) recent_bytes[i] = recent_bytes[i+1];
            recent_bytes[PATTERN_BYTES-1] = b;
            region_bytes = region_bytes + 1'b1;
            if (region_bytes >= n && window_hit(n)) begin
                if (passed_matches == skip_target) begin
                    off          = region_bytes - OFFSET_W'(n);
                    hit_reported = 1'b1;
                    scan_results_due.push_back(
                        t_scan_result'{1'b1, off, region_base + ADDR_W'(off)});
                end else begin
                    passed_matches = passed_matches + 1'b1;
                end
            end
        end
        // The final byte ends the region: report a miss if nothing was found, then re-arm.
        if (fin) begin
            if (!hit_reported) scan_results_due.push_back(t_scan_result'{1'b0, '0, '0});
            clear_region();
        end
    endtask

    // Compares one accepted result with the oldest prediction.
    task automatic check_result();
        t_scan_result want;
        if (scan_results_due.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
                $display("unexpected result: found=%0b offset=%0h address=%0h",
                         i_found, i_match_offset, i_match_address);
        end else begin
            want = scan_results_due.pop_front();
            if (want.found !== i_found || want.offset !== i_match_offset ||
                want.address !== i_match_address) begin
                fail_count++;
                if (fail_count <= 10)
                    $display({"result mismatch: expected found=%0b offset=%0h address=%0h,",
                              " got found=%0b offset=%0h address=%0h"},
                             want.found, want.offset, want.address,
                             i_found, i_match_offset, i_match_address);
            end
        end
    endtask

    // Results leave before new bytes enter, since a result always belongs to an older byte.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sig_bytes   = '0;
            sig_care    = '0;
            sig_len     = LEN_W'(1);
            skip_target = '0;
            region_base = '0;
            clear_region();
            scan_results_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) check_result();
            if (i_in_valid && i_in_ready) scan_byte(i_data_byte, i_last);
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[APB_ADDR_W-1:3]))
                    REG_PATTERN_LOW:  sig_bytes[63:0]   = i_pwdata[63:0];
                    REG_PATTERN_HIGH: sig_bytes[127:64] = i_pwdata[63:0];
                    REG_CARE_MASK:    sig_care          = i_pwdata[PATTERN_BYTES-1:0];
                    REG_PATTERN_LEN:  sig_len           = i_pwdata[LEN_W-1:0];
                    REG_SKIP_COUNT:   skip_target       = i_pwdata[SKIP_W-1:0];
                    REG_BASE_ADDRESS: region_base       = i_pwdata[ADDR_W-1:0];
                    default: ;
                endcase
            end
        end
        o_fail_count = fail_count;
        o_pending    = scan_results_due.size();
    end

endmodule

@@ bench/tb_masked_byte_pattern_scan_top.sv @@
`timescale 1ns / 1ps
// Testbench top of the masked byte pattern scanner: clock, reset, stimulus and verdict.
module tb_masked_byte_pattern_scan_top;
    import mbps_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned RANDOM_ITEMS = 1650;
    localparam int unsigned HOLD_CYCLES  = 300;

    typedef logic [7:0] t_region[$];

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    logic [7:0]            i_data_byte = '0;
    logic                  i_last      = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic                  o_found;
    logic [OFFSET_W-1:0]   o_match_offset;
    logic [ADDR_W-1:0]     o_match_address;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [APB_ADDR_W-1:0] paddr       = '0;
    logic [APB_DATA_W-1:0] pwdata      = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int unsigned fail_count;
    int unsigned pending;

    // Current settings, kept to shape the regions around the programmed pattern.
    logic [8*PATTERN_BYTES-1:0] cur_pattern = '0;
    logic [PATTERN_BYTES-1:0]   cur_care    = '0;
    logic [LEN_W-1:0]           cur_len     = LEN_W'(1);

    int unsigned src_idle_pct = 33;
    int unsigned snk_idle_pct = 33;
    logic        hold_kick    = 1'b0;
    logic        hold_used    = 1'b0;
    int unsigned hold_left    = 0;
    int unsigned items_sent   = 0;
    int unsigned cycle_count  = 0;

    always #2 i_clk = ~i_clk;

    masked_byte_pattern_scan_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_data_byte    (i_data_byte),
        .i_last         (i_last),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_found        (o_found),
        .o_match_offset (o_match_offset),
        .o_match_address(o_match_address),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    masked_byte_pattern_scan_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_data_byte    (i_data_byte),
        .i_last         (i_last),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_found        (o_found),
        .i_match_offset (o_match_offset),
        .i_match_address(o_match_address),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_pready       (pready),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // Result sink: random stalls, plus one long hold-off that backs the scanner up.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            hold_left   <= 0;
            hold_used   <= 1'b0;
        end else if (hold_kick && !hold_used) begin
            i_out_ready <= 1'b0;
            hold_left   <= HOLD_CYCLES;
            hold_used   <= 1'b1;
        end else if (hold_left != 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("masked_byte_pattern_scan_top regression: fail");
            $finish;
        end
    end

    // Offers one item and holds it until the scanner takes it.
    task automatic push_byte(input logic [7:0] b, input logic fin);
        logic taken;
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_last      <= fin;
        do begin
            @(negedge i_clk);
            taken = o_in_ready;
            @(posedge i_clk);
        end while (!taken);
        items_sent++;
    endtask

    task automatic send_region(input t_region r);
        foreach (r[i]) push_byte(r[i], i == r.size() - 1);
    endtask

    // Waits until every predicted result has come out, then lets the pipeline settle.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // One register write: setup cycle, then access cycle.
    task automatic write_reg(input t_reg_idx idx, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
    endtask

    task automatic program_scan(input logic [8*PATTERN_BYTES-1:0] pat,
                                input logic [PATTERN_BYTES-1:0] care,
                                input logic [LEN_W-1:0] len, input logic [SKIP_W-1:0] skip,
                                input logic [ADDR_W-1:0] base);
        cur_pattern = pat;
        cur_care    = care;
        cur_len     = len;
        write_reg(REG_PATTERN_LOW, pat[63:0]);
        write_reg(REG_PATTERN_HIGH, pat[127:64]);
        write_reg(REG_CARE_MASK, APB_DATA_W'(care));
        write_reg(REG_PATTERN_LEN, APB_DATA_W'(len));
        write_reg(REG_SKIP_COUNT, APB_DATA_W'(skip));
        write_reg(REG_BASE_ADDRESS, APB_DATA_W'(base));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Random settings, leaning toward short patterns and small skip counts.
    task automatic pick_config();
        logic [8*PATTERN_BYTES-1:0] pat;
        logic [PATTERN_BYTES-1:0]   care;
        logic [LEN_W-1:0]           len;
        logic [SKIP_W-1:0]          skip;
        logic [ADDR_W-1:0]          base;
        pat = {$urandom, $urandom, $urandom, $urandom};
        case ($urandom_range(5))
            0: care = '0;
            1: care = '1;
            default: care = PATTERN_BYTES'($urandom);
        endcase
        case ($urandom_range(9))
            0: len = LEN_W'($urandom_range(31));
            1: len = LEN_W'(16);
            default: len = LEN_W'($urandom_range(1, 8));
        endcase
        case ($urandom_range(7))
            0: skip = SKIP_W'($urandom);
            1, 2: skip = SKIP_W'($urandom_range(1, 3));
            default: skip = '0;
        endcase
        base = ($urandom_range(7) == 0) ? '1 : ADDR_W'({$urandom, $urandom});
        program_scan(pat, care, len, skip, base);
    endtask

    // Builds a region: mostly bytes near the pattern with a few planted copies,
    // some of them broken in one byte, and now and then plain noise.
    task automatic make_region(output t_region r);
        int unsigned n;
        int unsigned region_len;
        int unsigned hits;
        int unsigned pos;
        int unsigned k;
        n = (cur_len == 0) ? 1 : ((cur_len > PATTERN_BYTES) ? PATTERN_BYTES : int'(cur_len));
        r = {};
        region_len = ($urandom_range(9) == 0) ? $urandom_range(40, 100) : $urandom_range(1, 24);
        if ($urandom_range(5) == 0) begin
            repeat (region_len) r.push_back(8'($urandom));
        end else begin
            repeat (region_len) begin
                k = $urandom_range(PATTERN_BYTES - 1);
                r.push_back($urandom_range(1) ? cur_pattern[8*k +: 8] : 8'($urandom));
            end
            hits = $urandom_range(3);
            repeat (hits) begin
                if (n <= region_len) begin
                    pos = $urandom_range(region_len - n);
                    for (k = 0; k < n; k++) begin
                        if (cur_care[k]) r[pos+k] = cur_pattern[8*k +: 8];
                    end
                    if ($urandom_range(4) == 0) begin
                        k = $urandom_range(n - 1);
                        r[pos+k] = ~r[pos+k];
                    end
                end
            end
        end
    endtask

    initial begin
        t_region     r;
        int unsigned rand_start;
        int unsigned phase_start;
        int unsigned phase;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: empty care mask, so the first byte already matches.
        send_region({8'h00, 8'hFF});
        wait_idle();

        // Zero length acts as one; skip one match; the address wraps past the top.
        program_scan(128'h0000_0000_0000_00FF, 16'h0001, 5'd0, 16'd1, '1);
        send_region({8'hFF, 8'h00, 8'hFF});
        wait_idle();

        // Overlong length acts as sixteen; a short region ends without a match.
        program_scan({16{8'h78}}, 16'hFFFF, 5'd31, 16'd0, 48'h1234_5678_9ABC);
        send_region({8'h78, 8'h78});
        wait_idle();

        // Don't-care byte in the middle; bytes after the report are ignored.
        program_scan(128'h78_00_78, 16'h0005, 5'd3, 16'd0, 48'h0000_0000_1000);
        send_region({8'h78, 8'h55, 8'h78, 8'h11, 8'h78});
        wait_idle();

        // Largest skip count is never reached even though every window matches.
        program_scan('0, '0, 5'd1, 16'hFFFF, '0);
        send_region({8'h01, 8'h80, 8'h7F});
        wait_idle();

        // Pattern byte from the high word, matched on the final byte of the region.
        program_scan({56'h0, 8'hA5, 64'h0}, 16'h0100, 5'd9, 16'd0, 48'hFFFF_FFFF_FFF8);
        send_region({8'h5A, 8'h5A, 8'h5A, 8'h5A, 8'h5A, 8'h5A, 8'h5A, 8'h5A, 8'hA5});
        wait_idle();

        // Random phases: new settings, a batch of regions, then a drain.
        rand_start = items_sent;
        phase      = 0;
        while (items_sent - rand_start < RANDOM_ITEMS) begin
            src_idle_pct  = (phase >= 4 && phase < 8) ? 0 : 33;
            snk_idle_pct <= (phase >= 4 && phase < 8) ? 0 : 33;
            if (phase == 2) begin
                // Every one-byte region gives a result while the sink holds off.
                program_scan('0, '0, 5'd1, 16'd0, ADDR_W'({$urandom, $urandom}));
                src_idle_pct = 0;
                hold_kick   <= 1'b1;
                repeat (40) push_byte(8'($urandom), 1'b1);
            end else begin
                pick_config();
                phase_start = items_sent;
                while (items_sent - phase_start < 50) begin
                    make_region(r);
                    send_region(r);
                end
            end
            wait_idle();
            phase++;
        end

        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("masked_byte_pattern_scan_top regression: pass");
        end else begin
            $display("masked_byte_pattern_scan_top regression: fail");
        end
        $finish;
    end

endmodule
